// ===== hdl/ssfl_pkg.sv =====
// Shared types, constants and byte compare function for the substring search block.
package ssfl_pkg;

    localparam int MAX_NEEDLE_DEF = 16;
    localparam int MAX_TEXT_DEF   = 65536;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LOW  = 3'd0,
        REG_NEEDLE_HIGH = 3'd1,
        REG_NEEDLE_LEN  = 3'd2,
        REG_CASE_FOLD   = 3'd3,
        REG_REPORT_LAST = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [15:0] match_start;
        logic        text_overflow;
    } t_out;

    // Per-beat flags carried from the window stage to the match stage.
    typedef struct packed {
        logic last;
        logic ovf;
    } t_item_ctl;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic bytes_match(input logic [7:0] t, input logic [7:0] n,
                                         input logic fold);
        bytes_match = (t == n) || (fold && is_letter(t) && ((t ^ n) == CASE_BIT));
    endfunction

endpackage

// ===== hdl/ssfl_window.sv =====
// Input stage: byte window shift register, saturating text position and overflow tracking.
module ssfl_window #(
    parameter int MAX_NEEDLE = ssfl_pkg::MAX_NEEDLE_DEF,
    parameter int MAX_TEXT   = ssfl_pkg::MAX_TEXT_DEF,
    parameter int CW         = $clog2(MAX_TEXT + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  ssfl_pkg::t_in                 i_in,
    input  logic                          i_advance,
    output logic                          o_valid,
    output logic [MAX_NEEDLE-1:0][7:0]    o_window,
    output logic [CW-1:0]                 o_index,
    output ssfl_pkg::t_item_ctl           o_ctl
);
    import ssfl_pkg::*;

    logic [MAX_NEEDLE-1:0][7:0] r_window;
    logic [CW-1:0]              r_count;
    logic                       r_ovf;
    logic                       r_valid;
    logic [CW-1:0]              r_index;
    t_item_ctl                  r_ctl;
    logic                       sat;
    logic                       ovf_item;

    assign sat      = (r_count >= CW'(MAX_TEXT));
    assign ovf_item = r_ovf | sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_valid <= 1'b1;
                // start a new text after the final beat
                if (i_in.final_byte) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_count <= sat ? r_count : r_count + CW'(1);
                    r_ovf   <= ovf_item;
                end
            end else if (i_advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_window[0] <= i_in.text_byte;
            for (int i = 1; i < MAX_NEEDLE; i++) begin
                r_window[i] <= r_window[i-1];
            end
            r_index   <= r_count;
            r_ctl.last <= i_in.final_byte;
            r_ctl.ovf  <= ovf_item;
        end
    end

    assign o_valid  = r_valid;
    assign o_window = r_window;
    assign o_index  = r_index;
    assign o_ctl    = r_ctl;

endmodule

// ===== hdl/ssfl_match.sv =====
// Match stage: window compare, kept match start and result register.
module ssfl_match #(
    parameter int MAX_NEEDLE = ssfl_pkg::MAX_NEEDLE_DEF,
    parameter int MAX_TEXT   = ssfl_pkg::MAX_TEXT_DEF,
    parameter int CW         = $clog2(MAX_TEXT + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [MAX_NEEDLE-1:0][7:0]    i_window,
    input  logic [CW-1:0]                 i_index,
    input  ssfl_pkg::t_item_ctl           i_ctl,
    input  logic [MAX_NEEDLE-1:0][7:0]    i_needle,
    input  logic [4:0]                    i_needle_len,
    input  logic                          i_case_fold,
    input  logic                          i_report_last,
    input  logic                          i_out_ready,
    output logic                          o_advance,
    output logic                          o_out_valid,
    output ssfl_pkg::t_out                o_out
);
    import ssfl_pkg::*;

    localparam int WIX  = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int PMAX = ((MAX_TEXT - 1) < 65535) ? (MAX_TEXT - 1) : 65535;

    logic [4:0]  len_eff;
    logic [4:0]  sel;
    logic        hit;
    logic [CW:0] idx1;
    logic [CW:0] pos;
    logic [15:0] pos_sat;
    logic        take;
    logic        n_match_seen;
    logic [15:0] n_kept;

    logic        r_match_seen;
    logic [15:0] r_kept;
    logic        r_out_valid;
    t_out        r_out;

    assign len_eff = (i_needle_len > 5'(MAX_NEEDLE)) ? 5'(MAX_NEEDLE) : i_needle_len;

    // Needle byte k lines up with window entry len-1-k.
    always_comb begin
        hit = (len_eff != 5'd0);
        sel = '0;
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            sel = 5'(len_eff - 5'(k) - 5'd1);
            if ((5'(k) < len_eff) &&
                !bytes_match(i_window[sel[WIX-1:0]], i_needle[k], i_case_fold)) begin
                hit = 1'b0;
            end
        end
    end

    assign idx1    = {1'b0, i_index} + (CW+1)'(1);
    assign pos     = idx1 - (CW+1)'(len_eff);
    assign pos_sat = (pos > (CW+1)'(PMAX)) ? 16'(PMAX) : pos[15:0];

    assign take = hit && (idx1 >= (CW+1)'(len_eff)) && (i_report_last || !r_match_seen);
    assign n_match_seen = r_match_seen | take;
    assign n_kept       = take ? pos_sat : r_kept;

    // Only a final beat needs the result register free.
    assign o_advance = i_valid && (!i_ctl.last || !r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_seen <= 1'b0;
            r_kept       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_advance && i_ctl.last) begin
                r_out_valid  <= 1'b1;
                r_match_seen <= 1'b0;
                r_kept       <= '0;
            end else begin
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
                if (o_advance) begin
                    r_match_seen <= n_match_seen;
                    r_kept       <= n_kept;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_ctl.last) begin
            r_out.found         <= n_match_seen;
            r_out.match_start   <= n_match_seen ? n_kept : 16'd0;
            r_out.text_overflow <= i_ctl.ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/substring_search_first_last_top.sv =====
// Top level of the streaming substring search: configuration registers and stage wiring.
//
// Streams one text byte per beat and searches it for a needle of 1 to 16 bytes, with optional
// ASCII case folding, keeping either the first or the last match start of the text. The block
// takes one byte every clock cycle unless a final byte waits on the output side: a byte is
// shifted into the comparison window register when accepted, all needle positions are compared in
// parallel from that register, and the result for a text is loaded into the output register
// once the final byte has been compared and that register is free or being read. Only the final byte of
// a text ever waits on the output side; while its result beat is held, input ready drops. Match
// starts saturate at the smaller of MAX_TEXT-1 and 65535, and a text longer than MAX_TEXT bytes
// is flagged in text_overflow. Configuration writes are always accepted and should only be made
// while no text is in flight; a needle length of zero never matches, and one above
// MAX_NEEDLE is taken as MAX_NEEDLE.
module substring_search_first_last_top #(
    parameter int MAX_NEEDLE = ssfl_pkg::MAX_NEEDLE_DEF,
    parameter int MAX_TEXT   = ssfl_pkg::MAX_TEXT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ssfl_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ssfl_pkg::t_out                  o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssfl_pkg::*;

    localparam int CW = $clog2(MAX_TEXT + 1);

    // configuration registers
    logic [63:0] r_needle_low;
    logic [63:0] r_needle_high;
    logic [4:0]  r_needle_len;
    logic        r_case_fold;
    logic        r_report_last;

    logic [127:0]               needle_all;
    logic [MAX_NEEDLE-1:0][7:0] needle;

    logic                       accept;
    logic                       advance;
    logic                       s1_valid;
    logic [MAX_NEEDLE-1:0][7:0] window;
    logic [CW-1:0]              index;
    t_item_ctl                  ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= 5'd1;
            r_case_fold   <= 1'b0;
            r_report_last <= 1'b0;
        end else if (i_cfg_valid) begin
            // writes beyond the register list are dropped
            case (t_reg_idx'(i_cfg_index))
                REG_NEEDLE_LOW:  r_needle_low  <= i_cfg_data;
                REG_NEEDLE_HIGH: r_needle_high <= i_cfg_data;
                REG_NEEDLE_LEN:  r_needle_len  <= i_cfg_data[4:0];
                REG_CASE_FOLD:   r_case_fold   <= i_cfg_data[0];
                REG_REPORT_LAST: r_report_last <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign needle_all = {r_needle_high, r_needle_low};
    assign needle     = needle_all[8*MAX_NEEDLE-1:0];

    // Take a new beat whenever the compare stage is empty or moving on.
    assign o_in_ready = !s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    ssfl_window #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .MAX_TEXT   (MAX_TEXT),
        .CW         (CW)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_window  (window),
        .o_index   (index),
        .o_ctl     (ctl)
    );

    ssfl_match #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .MAX_TEXT   (MAX_TEXT),
        .CW         (CW)
    ) u_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_valid),
        .i_window      (window),
        .i_index       (index),
        .i_ctl         (ctl),
        .i_needle      (needle),
        .i_needle_len  (r_needle_len),
        .i_case_fold   (r_case_fold),
        .i_report_last (r_report_last),
        .i_out_ready   (i_out_ready),
        .o_advance     (advance),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out)
    );

endmodule

// ===== tb/sv/substring_search_first_last_top_test.sv =====
// Self-checking testbench for the streaming substring search: directed plan and random phases.
module substring_search_first_last_top_test;
    import ssfl_pkg::*;

    localparam int unsigned TEXT_CAP   = MAX_TEXT_DEF;
    localparam int unsigned WIN_DEPTH  = 16;
    localparam int unsigned SETTLE_CYC = 4;     // pipe drain after the last owed result
    localparam int unsigned HOLD_CYC   = 150;   // long receiver hold-off
    localparam int unsigned RAND_BYTES = 1150;
    localparam int unsigned CALM_AFTER = 1000;  // no idling past this many random beats
    localparam int unsigned PHASE_LEN  = 90;
    localparam int unsigned RUN_CYCLES = 1000000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    substring_search_first_last_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search predictor: its own copy of the registers and per-text state
    // ------------------------------------------------------------------
    logic [63:0] ndl_lo;
    logic [63:0] ndl_hi;
    logic [4:0]  ndl_len;
    logic        fold_on;
    logic        keep_last;

    logic [7:0]  window [WIN_DEPTH];   // entry 0 holds the newest text byte
    int unsigned text_count;           // bytes of the current text, saturating at TEXT_CAP
    logic        hit_seen;
    int unsigned hit_pos;
    logic        text_ovf;

    t_out        pending_results[$];   // results still owed by the block
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;

    // Stimulus shaping shared by the sender and the receiver.
    bit          calm      = 1'b0;
    int unsigned idle_pct  = 10;
    bit          hold_req  = 1'b0;

    function automatic void clear_text();
        foreach (window[k]) window[k] = 8'h00;
        text_count = 0;
        hit_seen   = 1'b0;
        hit_pos    = 0;
        text_ovf   = 1'b0;
    endfunction

    // A letter folded to lower case lands in a..z; nothing else does.
    function automatic bit is_alpha(logic [7:0] c);
        logic [7:0] lc;
        lc = c | CASE_BIT;
        return (lc >= 8'h61) && (lc <= 8'h7A);
    endfunction

    function automatic bit byte_eq(logic [7:0] t, logic [7:0] n);
        return (t == n) || (fold_on && is_alpha(t) && ((t ^ n) == CASE_BIT));
    endfunction

    function automatic logic [7:0] needle_at(int unsigned k);
        logic [127:0] whole;
        whole = {ndl_hi, ndl_lo};
        return whole[k*8 +: 8];
    endfunction

    // Needle lengths beyond the window clamp to the window depth.
    function automatic int unsigned eff_len();
        return (ndl_len > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : int'(ndl_len);
    endfunction

    // Advance the search by one text byte; returns 1 with the result on a final byte.
    function automatic bit search_step(input logic [7:0] t, input logic fin,
                                       output t_out res);
        int unsigned len;
        int unsigned pos_now;
        int unsigned pos;
        bit          hit;
        len = eff_len();
        // past the cap every byte takes the saturated position and flags overflow
        if (text_count >= TEXT_CAP) begin
            text_ovf = 1'b1;
            pos_now  = TEXT_CAP;
        end else begin
            pos_now = text_count;
            text_count++;
        end
        for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = t;
        if (len != 0 && pos_now + 1 >= len) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++)
                if (!byte_eq(window[len-1-k], needle_at(k))) hit = 1'b0;
            if (hit && (keep_last || !hit_seen)) begin
                pos = pos_now + 1 - len;
                if (pos > TEXT_CAP - 1) pos = TEXT_CAP - 1;
                if (pos > 32'hFFFF) pos = 32'hFFFF;
                hit_pos  = pos;
                hit_seen = 1'b1;
            end
        end
        res = '0;
        if (!fin) return 1'b0;
        res.found         = hit_seen;
        res.match_start   = hit_seen ? hit_pos[15:0] : 16'd0;
        res.text_overflow = text_ovf;
        clear_text();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing owed: found=%0b start=%0d ovf=%0b",
                                        o_out.found, o_out.match_start, o_out.text_overflow));
            end else begin
                w = pending_results.pop_front();
                if (o_out.found !== w.found)
                    flag_mismatch($sformatf("found %0b, want %0b", o_out.found, w.found));
                if (o_out.match_start !== w.match_start)
                    flag_mismatch($sformatf("match_start %0d, want %0d",
                                            o_out.match_start, w.match_start));
                if (o_out.text_overflow !== w.text_overflow)
                    flag_mismatch($sformatf("text_overflow %0b, want %0b",
                                            o_out.text_overflow, w.text_overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // hold off long enough for the block to back up and drop input ready
                i_out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drop valid and wait until every owed result is in, then let the pipe empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Register writes only go in with the block idle.
    task automatic write_reg(input t_reg_idx r, input logic [63:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (r)
            REG_NEEDLE_LOW:  ndl_lo    = v;
            REG_NEEDLE_HIGH: ndl_hi    = v;
            REG_NEEDLE_LEN:  ndl_len   = v[4:0];
            REG_CASE_FOLD:   fold_on   = v[0];
            REG_REPORT_LAST: keep_last = v[0];
            default: ;
        endcase
    endtask

    // Offer one text beat, hold it until accepted, then book the expected result.
    // A typed result replaces the predicted one in the queue.
    task automatic offer_byte(input logic [7:0] t, input logic fin,
                              input bit typed, input t_out typed_res);
        t_out res;
        bit   has;
        if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{text_byte: t, final_byte: fin};
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        has = search_step(t, fin, res);
        if (has) pending_results.push_back(typed ? typed_res : res);
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(8'h41, 8'h5A)) | (($urandom_range(0, 1) != 0) ? CASE_BIT : 8'h00);
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (is_alpha(c) && $urandom_range(0, 3) == 0) return c ^ CASE_BIT;
        return c;
    endfunction

    // Text bytes lean towards the needle so partial and full matches are common.
    function automatic logic [7:0] pick_byte(int unsigned len);
        case ($urandom_range(0, 4))
            0, 1:    return (len != 0) ? flip_case(needle_at($urandom_range(0, len - 1)))
                                       : 8'($urandom);
            2:       return rand_letter();
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        logic [127:0] pat;
        logic [4:0]   n;
        for (int k = 0; k < 16; k++)
            pat[k*8 +: 8] = ($urandom_range(0, 1) != 0) ? rand_letter() : 8'($urandom);
        // mostly short needles, with the extremes and the clamped lengths now and then
        case ($urandom_range(0, 11))
            0:       n = 5'd0;
            1:       n = 5'd16;
            2:       n = 5'($urandom_range(17, 31));
            3:       n = 5'($urandom_range(9, 15));
            default: n = 5'($urandom_range(1, 5));
        endcase
        write_reg(REG_NEEDLE_LOW,  pat[63:0]);
        write_reg(REG_NEEDLE_HIGH, pat[127:64]);
        write_reg(REG_NEEDLE_LEN,  64'(n));
        write_reg(REG_CASE_FOLD,   64'($urandom_range(0, 1)));
        write_reg(REG_REPORT_LAST, 64'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 5;
            2:       idle_pct = 15;
            default: idle_pct = 30;
        endcase
    endtask

    // One text with random content, usually carrying one or two copies of the needle.
    task automatic random_text(input int unsigned longest);
        logic [7:0]  txt[$];
        int unsigned n;
        int unsigned len;
        int unsigned at;
        len = eff_len();
        n   = $urandom_range(1, longest);
        repeat (n) txt.push_back(pick_byte(len));
        if (len != 0 && n >= len && $urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 2)) begin
                at = $urandom_range(0, n - len);
                for (int k = 0; k < len; k++) txt[at + k] = flip_case(needle_at(k));
            end
        end
        foreach (txt[i]) offer_byte(txt[i], i == n - 1, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Directed plan: register writes and text beats, walked in order
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_reg;
        t_reg_idx    reg_sel;
        logic [63:0] reg_val;
        logic [7:0]  text_byte;
        int unsigned reps;
        logic        closes;     // last copy carries the final flag
        bit          typed;
        t_out        want;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic void plan_reg(t_reg_idx r, logic [63:0] v);
        t_plan_row p;
        p.is_reg  = 1'b1;
        p.reg_sel = r;
        p.reg_val = v;
        plan.push_back(p);
    endfunction

    function automatic void plan_txt(logic [7:0] t, int unsigned reps, logic fin,
                                     bit typed = 1'b0, logic f = 1'b0,
                                     logic [15:0] s = 16'd0, logic o = 1'b0);
        t_plan_row p;
        p.is_reg    = 1'b0;
        p.text_byte = t;
        p.reps      = reps;
        p.closes    = fin;
        p.typed     = typed;
        p.want      = '{found: f, match_start: s, text_overflow: o};
        plan.push_back(p);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_plan_row   row;
        int unsigned rand_start;
        int unsigned target;
        int unsigned phase;

        ndl_lo    = '0;
        ndl_hi    = '0;
        ndl_len   = 5'd1;
        fold_on   = 1'b0;
        keep_last = 1'b0;
        clear_text();

        // out of reset the needle is a single zero byte
        plan_txt(8'h00, 1, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0);
        plan_txt(8'hFF, 1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);
        // needle "Ab": exact match one byte in
        plan_reg(REG_NEEDLE_LOW, 64'h6241);
        plan_reg(REG_NEEDLE_LEN, 64'd2);
        plan_txt(8'h78, 1, 1'b0);
        plan_txt(8'h41, 1, 1'b0);
        plan_txt(8'h62, 1, 1'b1, 1'b1, 1'b1, 16'd1, 1'b0);
        // "aB" misses with exact compare, hits with case folding
        plan_txt(8'h61, 1, 1'b0);
        plan_txt(8'h42, 1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);
        plan_reg(REG_CASE_FOLD, 64'd1);
        plan_txt(8'h61, 1, 1'b0);
        plan_txt(8'h42, 1, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0);
        // text shorter than the needle
        plan_txt(8'h41, 1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);
        // '@' against '`' differ only in the case bit but are not letters
        plan_reg(REG_NEEDLE_LOW, 64'h40);
        plan_reg(REG_NEEDLE_LEN, 64'd1);
        plan_txt(8'h60, 1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);
        // keep the last of two matches
        plan_reg(REG_NEEDLE_LOW, 64'h61);
        plan_reg(REG_CASE_FOLD, 64'd0);
        plan_reg(REG_REPORT_LAST, 64'd1);
        plan_txt(8'h61, 1, 1'b0);
        plan_txt(8'h58, 1, 1'b0);
        plan_txt(8'h61, 1, 1'b1, 1'b1, 1'b1, 16'd2, 1'b0);
        // zero needle length never matches, even a zero byte against a zero needle
        plan_reg(REG_NEEDLE_LOW, 64'h0);
        plan_reg(REG_NEEDLE_LEN, 64'd0);
        plan_txt(8'h00, 1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);
        // largest length code clamps to the full sixteen-byte window
        plan_reg(REG_NEEDLE_LOW,  64'hFFFF_FFFF_FFFF_FFFF);
        plan_reg(REG_NEEDLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_reg(REG_NEEDLE_LEN,  64'd31);
        plan_txt(8'hFF, 16, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0);
        plan_reg(REG_NEEDLE_LEN,  64'd16);
        plan_txt(8'hFF, 1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_reg) begin
                write_reg(row.reg_sel, row.reg_val);
            end else begin
                for (int j = 0; j < row.reps; j++)
                    offer_byte(row.text_byte, row.closes && (j == row.reps - 1),
                               row.typed, row.want);
            end
        end

        // Random phases: fresh registers each time, the block drained in between.
        rand_start = bytes_sent;
        phase      = 0;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            random_setup();
            calm = (bytes_sent - rand_start >= CALM_AFTER);
            // one phase of very short texts against a long receiver hold-off
            if (phase == 2) hold_req = 1'b1;
            target = bytes_sent + PHASE_LEN;
            while (bytes_sent < target)
                random_text((phase == 2) ? 3 : (($urandom_range(0, 7) == 0) ? 60 : 20));
            phase++;
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hang guard, several times the slowest legal run.
    initial begin
        #(RUN_CYCLES * 8);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
